>>> hw/rtl/fwm_pkg.sv
// Shared types, constants and helper functions for the filename wildcard matcher.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package fwm_pkg;

  // Field and port widths.
  localparam int unsigned CharW    = 8;
  localparam int unsigned PosW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  // Template geometry: register bytes, bytes in the low register, positions a
  // 4-bit index can reach.
  localparam int unsigned TemplateCharsDefault = 12;
  localparam int unsigned RegChars             = 12;
  localparam int unsigned LowChars             = 8;
  localparam int unsigned MaxChars             = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgTmplLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTmplHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTmplLen  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgFoldCase = 2'd3;

  // Special characters.
  localparam logic [CharW-1:0] DotChar   = 8'h2E;
  localparam logic [CharW-1:0] QueryChar = 8'h3F;
  localparam logic [CharW-1:0] StarChar  = 8'h2A;
  localparam logic [CharW-1:0] LowerA    = 8'h61;
  localparam logic [CharW-1:0] LowerZ    = 8'h7A;
  localparam logic [CharW-1:0] CaseDelta = 8'h20;

  // Template summary handed from the configuration block to the matcher.
  typedef struct packed {
    logic [PosW-1:0] len;        // clamped template length
    logic [PosW-1:0] dot;        // first dot, or the length when there is none
    logic [PosW-1:0] ext_start;  // first extension position
    logic            ext_star;   // character at ext_start is a star
    logic            fold;       // case folding enabled
  } tmpl_info_t;

  // Fold a lower-case letter to upper case when folding is enabled.
  function automatic logic [CharW-1:0] fold_char(input logic [CharW-1:0] c,
                                                 input logic             en);
    logic [CharW-1:0] r;
    r = c;
    if (en && (c >= LowerA) && (c <= LowerZ)) begin
      r = c - CaseDelta;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/filename_wildcard_matcher.sv
// Filename wildcard matcher: one name character per request, verdict on the end marker.
// A request is taken into the input register and then updates the matcher state;
// an end marker's verdict goes into the result register. Throughput: one request per
// cycle; the input holds only while a verdict waits. Reset clears the valid flags and
// matcher state, not the held character or result bit, and loads the configuration
// reset values; no clearing pass. Depends on fwm_pkg, fwm_template and fwm_match.
`default_nettype none

module filename_wildcard_matcher #(
  parameter int unsigned TemplateChars = fwm_pkg::TemplateCharsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [fwm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [fwm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [fwm_pkg::CharW-1:0]     name_char_i,
  input  wire logic                          end_of_name_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               matched_o
);

  fwm_pkg::tmpl_info_t        tmpl;
  logic [fwm_pkg::CharW-1:0]  chars [fwm_pkg::MaxChars];
  logic                       in_valid_q;
  logic [fwm_pkg::CharW-1:0]  char_q;
  logic                       end_q;
  logic                       blocked;
  logic                       fire;
  logic                       verdict;
  logic                       out_valid_q;
  logic                       matched_q;

  fwm_template #(
    .TemplateChars (TemplateChars)
  ) u_template (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tmpl_o      (tmpl),
    .chars_o     (chars)
  );

  // An end marker waits in the input register while a verdict is still unread.
  assign blocked    = in_valid_q && end_q && out_valid_q && out_stall_i;
  assign fire       = in_valid_q && !blocked;
  assign in_stall_o = blocked;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!blocked) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!blocked && in_valid_i) begin
      char_q <= name_char_i;
      end_q  <= end_of_name_i;
    end
  end

  fwm_match u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .end_i     (end_q),
    .char_i    (char_q),
    .tmpl_i    (tmpl),
    .chars_i   (chars),
    .verdict_o (verdict)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && end_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && end_q) begin
      matched_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

endmodule

`default_nettype wire

>>> hw/rtl/fwm_template.sv
// Configuration registers of the matcher and the derived template summary.
// Depends on fwm_pkg.
`default_nettype none

module fwm_template #(
  parameter int unsigned TemplateChars = fwm_pkg::TemplateCharsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fwm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [fwm_pkg::CfgDataW-1:0]   cfg_data_i,
  output fwm_pkg::tmpl_info_t                 tmpl_o,
  output logic [fwm_pkg::CharW-1:0]           chars_o [fwm_pkg::MaxChars]
);

  localparam int unsigned StoredChars =
    (TemplateChars < fwm_pkg::RegChars) ? TemplateChars : fwm_pkg::RegChars;
  localparam logic [fwm_pkg::PosW:0] LenCap = (fwm_pkg::PosW + 1)'(TemplateChars);

  logic                       we_low, we_high, we_len, we_fold;
  logic [fwm_pkg::PosW-1:0]   len_q;
  logic                       fold_q;
  logic [fwm_pkg::PosW-1:0]   len_eff;
  logic [fwm_pkg::PosW-1:0]   dot;
  logic [fwm_pkg::PosW-1:0]   ext_start;
  logic [fwm_pkg::CharW-1:0]  chars [fwm_pkg::MaxChars];

  // Decode the register index into write enables.
  always_comb begin
    we_low  = 1'b0;
    we_high = 1'b0;
    we_len  = 1'b0;
    we_fold = 1'b0;
    case (cfg_index_i)
      fwm_pkg::CfgTmplLow:  we_low  = cfg_we_i;
      fwm_pkg::CfgTmplHigh: we_high = cfg_we_i;
      fwm_pkg::CfgTmplLen:  we_len  = cfg_we_i;
      fwm_pkg::CfgFoldCase: we_fold = cfg_we_i;
      default: ;
    endcase
  end

  // Template bytes; only the positions the length can reach are stored.
  for (genvar g = 0; g < StoredChars; g++) begin : g_char
    logic [fwm_pkg::CharW-1:0] char_q;
    if (g < fwm_pkg::LowChars) begin : g_low
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          char_q <= '0;
        end else if (we_low) begin
          char_q <= cfg_data_i[fwm_pkg::CharW*g +: fwm_pkg::CharW];
        end
      end
    end else begin : g_high
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          char_q <= '0;
        end else if (we_high) begin
          char_q <= cfg_data_i[fwm_pkg::CharW*(g-fwm_pkg::LowChars) +: fwm_pkg::CharW];
        end
      end
    end
    assign chars[g] = fwm_pkg::fold_char(char_q, fold_q);
  end

  // Positions beyond the stored bytes read as zero.
  for (genvar g = StoredChars; g < fwm_pkg::MaxChars; g++) begin : g_zero
    assign chars[g] = '0;
  end

  // Length and case-folding registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      fold_q <= 1'b1;
    end else begin
      if (we_len) begin
        len_q <= cfg_data_i[fwm_pkg::PosW-1:0];
      end
      if (we_fold) begin
        fold_q <= cfg_data_i[0];
      end
    end
  end

  // Clamp the length to the template capacity.
  assign len_eff = ({1'b0, len_q} > LenCap) ? LenCap[fwm_pkg::PosW-1:0] : len_q;

  // Find the first dot inside the valid length; lowest position wins.
  always_comb begin
    dot = len_eff;
    for (int i = fwm_pkg::MaxChars - 1; i >= 0; i--) begin
      if ((fwm_pkg::PosW'(i) < len_eff) && (chars[i] == fwm_pkg::DotChar)) begin
        dot = fwm_pkg::PosW'(i);
      end
    end
  end

  assign ext_start = (dot < len_eff) ? dot + 1'b1 : dot;

  assign tmpl_o.len       = len_eff;
  assign tmpl_o.dot       = dot;
  assign tmpl_o.ext_start = ext_start;
  assign tmpl_o.ext_star  = (chars[ext_start] == fwm_pkg::StarChar);
  assign tmpl_o.fold      = fold_q;
  assign chars_o          = chars;

endmodule

`default_nettype wire

>>> hw/rtl/fwm_match.sv
// Per-name matching state and the per-character step and verdict logic.
// Depends on fwm_pkg.
`default_nettype none

module fwm_match (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire logic                          end_i,
  input  wire logic [fwm_pkg::CharW-1:0]     char_i,
  input  wire fwm_pkg::tmpl_info_t           tmpl_i,
  input  wire logic [fwm_pkg::CharW-1:0]     chars_i [fwm_pkg::MaxChars],
  output logic                               verdict_o
);

  logic [fwm_pkg::PosW-1:0]  pos_q, pos_d;
  logic                      in_ext_q, in_ext_d;
  logic                      skip_q, skip_d;
  logic                      failed_q, failed_d;
  logic                      star_q, star_d;
  logic [fwm_pkg::CharW-1:0] c;
  logic [fwm_pkg::CharW-1:0] t;
  logic                      hit;
  logic                      name_short;

  assign c   = fwm_pkg::fold_char(char_i, tmpl_i.fold);
  assign t   = chars_i[pos_q];
  assign hit = (c == t) || (t == fwm_pkg::QueryChar);

  // The template name part still holds a character that is not a star.
  assign name_short = !skip_q && (pos_q < tmpl_i.dot) && (t != fwm_pkg::StarChar);

  // Advance the state by one character, or clear it at the end of a name.
  always_comb begin
    pos_d    = pos_q;
    in_ext_d = in_ext_q;
    skip_d   = skip_q;
    failed_d = failed_q;
    star_d   = star_q;
    if (fire_i) begin
      if (end_i) begin
        pos_d    = '0;
        in_ext_d = 1'b0;
        skip_d   = 1'b0;
        failed_d = 1'b0;
        star_d   = 1'b0;
      end else if (failed_q || star_q) begin
        // The outcome is settled; ignore further characters.
      end else if (!in_ext_q) begin
        if (c == fwm_pkg::DotChar) begin
          if (name_short) begin
            failed_d = 1'b1;
          end
          in_ext_d = 1'b1;
          skip_d   = 1'b0;
          pos_d    = tmpl_i.ext_start;
        end else if (skip_q) begin
          // A star swallows the rest of the name part.
        end else if (pos_q >= tmpl_i.dot) begin
          failed_d = 1'b1;
        end else if (hit) begin
          pos_d = pos_q + 1'b1;
        end else if (t == fwm_pkg::StarChar) begin
          skip_d = 1'b1;
        end else begin
          failed_d = 1'b1;
        end
      end else begin
        if (pos_q >= tmpl_i.len) begin
          failed_d = 1'b1;
        end else if (hit) begin
          pos_d = pos_q + 1'b1;
        end else if (t == fwm_pkg::StarChar) begin
          star_d = 1'b1;
        end else begin
          failed_d = 1'b1;
        end
      end
    end
  end

  // Verdict for an end marker, from the state before it.
  always_comb begin
    if (failed_q) begin
      verdict_o = 1'b0;
    end else if (star_q) begin
      verdict_o = 1'b1;
    end else if (!in_ext_q) begin
      if (name_short) begin
        verdict_o = 1'b0;
      end else begin
        verdict_o = (tmpl_i.ext_start >= tmpl_i.len) || tmpl_i.ext_star;
      end
    end else begin
      verdict_o = (pos_q >= tmpl_i.len) || (t == fwm_pkg::StarChar);
    end
  end

  // Per-name state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      in_ext_q <= 1'b0;
      skip_q   <= 1'b0;
      failed_q <= 1'b0;
      star_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      in_ext_q <= in_ext_d;
      skip_q   <= skip_d;
      failed_q <= failed_d;
      star_q   <= star_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fwm_checker.sv
// Port-level checks for the filename wildcard matcher, bound to the top level.
// Depends on filename_wildcard_matcher.
`default_nettype none

module fwm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          end_of_name_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic                          matched_o
);

  logic end_taken;

  assign end_taken = in_valid_i && !in_stall_o && end_of_name_i;

  // A stalled verdict stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(matched_o))
    else $error("stalled verdict changed or dropped");

  // The input only holds back while a verdict is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting verdict");

  // A new verdict appears only after its end marker was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(end_taken, 2))
    else $error("verdict without an end marker");

  // Every end marker taken leads to a verdict on the port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_taken |-> ##2 out_valid_o)
    else $error("end marker lost");

endmodule

bind filename_wildcard_matcher fwm_checker u_fwm_checker (.*);

`default_nettype wire

>>> tb/filename_wildcard_matcher_test.sv
// Self-checking testbench for the filename wildcard matcher: a directed table of names and
// templates, then random templates with names derived from them, checked against a predictor
// or typed-in verdicts. Depends on fwm_pkg and filename_wildcard_matcher.
module filename_wildcard_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned SettleCyc   = 3;
  localparam int unsigned DirRowCount = 9;
  localparam int unsigned PhaseCount  = 24;
  localparam int unsigned PhaseItems  = 60;

  // How the verdict of a name is obtained: typed in by hand, or from the predictor.
  typedef enum logic [1:0] {
    VerdictNo,
    VerdictYes,
    VerdictPredicted
  } verdict_kind_t;

  // One directed case. Texts are right-justified string literals; bytes to the left of a
  // text, up to its length, read as zero.
  typedef struct packed {
    logic [95:0]   tmpl_text;
    logic [3:0]    tmpl_len;
    logic          fold;
    logic [63:0]   name_text;
    logic [3:0]    name_len;
    verdict_kind_t kind;
  } dir_row_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [fwm_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [fwm_pkg::CfgDataW-1:0] cfg_data_i    = '0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_stall_o;
  logic [fwm_pkg::CharW-1:0]    name_char_i   = '0;
  logic                         end_of_name_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i   = 1'b0;
  logic                         matched_o;

  verdict_kind_t typed_verdict = VerdictPredicted;
  int unsigned   src_idle_pct  = 0;
  int unsigned   sink_idle_pct = 0;
  int unsigned   cycle_count   = 0;
  int unsigned   mismatches    = 0;

  // Expected verdicts, oldest first.
  logic pending_verdicts [$];

  // Predictor copy of the configuration and of the per-name state.
  logic [63:0]   cfg_low  = '0;
  logic [31:0]   cfg_high = '0;
  logic [3:0]    cfg_len  = '0;
  logic          cfg_fold = 1'b1;
  logic [3:0]    m_pos;
  logic          m_in_ext;
  logic          m_skip;
  logic          m_failed;
  logic          m_star;
  logic          verdict_now;

  // Stimulus generation state.
  logic [7:0]    gen_tmpl [12];
  logic [3:0]    gen_len;
  logic          gen_fold;
  logic [7:0]    name_buf [$];

  filename_wildcard_matcher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .name_char_i  (name_char_i),
    .end_of_name_i(end_of_name_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .matched_o    (matched_o)
  );

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Random stall on the result side.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < sink_idle_pct);
  end

  // Lower-case letters become upper case while folding is on.
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if (cfg_fold && c >= fwm_pkg::LowerA && c <= fwm_pkg::LowerZ) begin
      return c - fwm_pkg::CaseDelta;
    end
    return c;
  endfunction

  // Template character at a position; positions past the twelfth read as zero.
  function automatic logic [7:0] tmpl_char(input logic [3:0] i);
    if (i < 4'd8) begin
      return fold_upper(cfg_low[8*i +: 8]);
    end
    if (i < 4'd12) begin
      return fold_upper(cfg_high[8*(i-8) +: 8]);
    end
    return 8'h00;
  endfunction

  function automatic logic [3:0] tmpl_len_clamped();
    return (cfg_len > fwm_pkg::TemplateCharsDefault) ?
      4'(fwm_pkg::TemplateCharsDefault) : cfg_len;
  endfunction

  // Position of the first template dot, or the length when there is none.
  function automatic logic [3:0] first_dot();
    logic [3:0] n;
    n = tmpl_len_clamped();
    for (logic [4:0] i = 0; i < n; i++) begin
      if (tmpl_char(i[3:0]) == fwm_pkg::DotChar) begin
        return i[3:0];
      end
    end
    return n;
  endfunction

  function automatic logic [3:0] ext_begin();
    logic [3:0] d;
    d = first_dot();
    return (d < tmpl_len_clamped()) ? d + 4'd1 : d;
  endfunction

  function automatic void clear_name();
    m_pos    = '0;
    m_in_ext = 1'b0;
    m_skip   = 1'b0;
    m_failed = 1'b0;
    m_star   = 1'b0;
  endfunction

  // Advance the per-name state by one folded name character.
  function automatic void advance_name(input logic [7:0] c);
    logic [3:0] p;
    logic [7:0] t;
    p = m_pos;
    if (m_failed || m_star) begin
      return;
    end
    if (!m_in_ext) begin
      // The name's first dot closes the name part.
      if (c == fwm_pkg::DotChar) begin
        if (!m_skip && p < first_dot() && tmpl_char(p) != fwm_pkg::StarChar) begin
          m_failed = 1'b1;
        end
        m_in_ext = 1'b1;
        m_skip   = 1'b0;
        m_pos    = ext_begin();
        return;
      end
      if (m_skip) begin
        return;
      end
      if (p >= first_dot()) begin
        m_failed = 1'b1;
        return;
      end
      t = tmpl_char(p);
      if (c == t || t == fwm_pkg::QueryChar) begin
        m_pos = p + 4'd1;
      end else if (t == fwm_pkg::StarChar) begin
        m_skip = 1'b1;
      end else begin
        m_failed = 1'b1;
      end
      return;
    end
    // Extension part: a star accepts whatever follows.
    if (p >= tmpl_len_clamped()) begin
      m_failed = 1'b1;
      return;
    end
    t = tmpl_char(p);
    if (c == t || t == fwm_pkg::QueryChar) begin
      m_pos = p + 4'd1;
    end else if (t == fwm_pkg::StarChar) begin
      m_star = 1'b1;
    end else begin
      m_failed = 1'b1;
    end
  endfunction

  // Verdict for the name seen so far.
  function automatic logic name_verdict();
    logic [3:0] p;
    p = m_pos;
    if (m_failed) begin
      return 1'b0;
    end
    if (m_star) begin
      return 1'b1;
    end
    if (!m_in_ext) begin
      if (!m_skip && p < first_dot() && tmpl_char(p) != fwm_pkg::StarChar) begin
        return 1'b0;
      end
      p = ext_begin();
    end
    if (p >= tmpl_len_clamped()) begin
      return 1'b1;
    end
    return tmpl_char(p) == fwm_pkg::StarChar;
  endfunction

  // Monitor: checks verdicts, tracks configuration writes and predicts each accepted request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cfg_low  = '0;
      cfg_high = '0;
      cfg_len  = '0;
      cfg_fold = 1'b1;
      clear_name();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_verdicts.size() == 0) begin
          $error("matched: expected none, actual %0b", matched_o);
          mismatches++;
        end else begin
          verdict_now = pending_verdicts.pop_front();
          if (matched_o !== verdict_now) begin
            $error("matched: expected %0b, actual %0b", verdict_now, matched_o);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          fwm_pkg::CfgTmplLow: begin
            cfg_low = cfg_data_i;
          end
          fwm_pkg::CfgTmplHigh: begin
            cfg_high = cfg_data_i[31:0];
          end
          fwm_pkg::CfgTmplLen: begin
            cfg_len = cfg_data_i[3:0];
          end
          fwm_pkg::CfgFoldCase: begin
            cfg_fold = cfg_data_i[0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        if (end_of_name_i) begin
          verdict_now = name_verdict();
          clear_name();
          if (typed_verdict != VerdictPredicted) begin
            verdict_now = (typed_verdict == VerdictYes);
          end
          pending_verdicts.push_back(verdict_now);
        end else begin
          advance_name(fold_upper(name_char_i));
        end
      end
    end
  end

  // Directed cases.
  function automatic dir_row_t dir_row(input int idx);
    case (idx)
      // Reset configuration, empty name.
      0: begin
        return '{96'd0, 4'd0, 1'b1, 64'd0, 4'd0, VerdictYes};
      end
      // Wildcard facing the name's end.
      1: begin
        return '{"AB?", 4'd3, 1'b1, "ab", 4'd2, VerdictNo};
      end
      // Wildcard facing the name's dot.
      2: begin
        return '{"A?.C", 4'd4, 1'b1, "A.C", 4'd3, VerdictNo};
      end
      // Stars in both parts.
      3: begin
        return '{"*.T*", 4'd4, 1'b1, "XY.TXT", 4'd6, VerdictYes};
      end
      // Long template without folding.
      4: begin
        return '{"ABCDEFGHIJKL", 4'd15, 1'b0, "abc", 4'd3, VerdictPredicted};
      end
      // Zero bytes in template and name.
      5: begin
        return '{"A", 4'd3, 1'b1, "A", 4'd3, VerdictPredicted};
      end
      // Later dots are ordinary characters.
      6: begin
        return '{"A.B.C", 4'd5, 1'b1, "a.b.c", 4'd5, VerdictPredicted};
      end
      // Extreme character values against wildcards.
      7: begin
        return '{"??", 4'd2, 1'b1, 64'h00FF, 4'd2, VerdictPredicted};
      end
      // Case differs and folding is off.
      8: begin
        return '{"AB", 4'd2, 1'b0, "aB", 4'd2, VerdictNo};
      end
      default: begin
        return '{96'd0, 4'd0, 1'b1, 64'd0, 4'd0, VerdictPredicted};
      end
    endcase
  endfunction

  function automatic logic [7:0] text_byte(input logic [95:0] txt, input int n, input int i);
    return txt[8*(n-1-i) +: 8];
  endfunction

  // Random character, biased towards letters and the template's special characters.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 7))
      0: begin
        return "A";
      end
      1: begin
        return "B";
      end
      2: begin
        return "a";
      end
      3: begin
        return "b";
      end
      4: begin
        return fwm_pkg::DotChar;
      end
      5: begin
        return fwm_pkg::QueryChar;
      end
      6: begin
        return fwm_pkg::StarChar;
      end
      default: begin
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  task automatic write_reg(input logic [fwm_pkg::CfgIdxW-1:0]  idx,
                           input logic [fwm_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  // Pack the generated template and write all four registers.
  task automatic load_template();
    logic [63:0] lo;
    logic [31:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = gen_tmpl[i];
    end
    for (int i = 0; i < 4; i++) begin
      hi[8*i +: 8] = gen_tmpl[i+8];
    end
    write_reg(fwm_pkg::CfgTmplLow, lo);
    write_reg(fwm_pkg::CfgTmplHigh, {32'd0, hi});
    write_reg(fwm_pkg::CfgTmplLen, {60'd0, gen_len});
    write_reg(fwm_pkg::CfgFoldCase, {63'd0, gen_fold});
    cfg_we_i <= 1'b0;
  endtask

  // Present one request and hold it until it is accepted.
  task automatic send_request(input logic [7:0] c, input logic eon, input verdict_kind_t kind);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    name_char_i   <= c;
    end_of_name_i <= eon;
    typed_verdict <= kind;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic send_name(input verdict_kind_t kind);
    foreach (name_buf[i]) begin
      send_request(name_buf[i], 1'b0, VerdictPredicted);
    end
    send_request(8'($urandom_range(0, 255)), 1'b1, kind);
  endtask

  // Stop sending until every expected verdict has come, then let the block settle.
  task automatic drain_verdicts();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Random template; some phases take the extremes of the registers.
  task automatic new_template(input int phase);
    gen_fold = (phase % 3) != 0;
    for (int i = 0; i < 12; i++) begin
      gen_tmpl[i] = (phase % 8 == 0) ? 8'hFF : pick_char();
    end
    if (phase % 8 == 0) begin
      gen_len = 4'd15;
    end else if (phase % 8 == 1) begin
      gen_len = 4'd0;
    end else if ($urandom_range(0, 9) == 0) begin
      gen_len = 4'($urandom_range(13, 15));
    end else begin
      gen_len = 4'($urandom_range(1, 12));
    end
  endtask

  // Mostly names shaped after the template, sometimes mutated; the rest is noise.
  task automatic build_name();
    int         n;
    logic [7:0] c;
    name_buf.delete();
    if ($urandom_range(0, 9) < 3) begin
      n = $urandom_range(0, 10);
      repeat (n) name_buf.push_back(pick_char());
    end else begin
      n = (gen_len > 12) ? 12 : gen_len;
      for (int i = 0; i < n; i++) begin
        c = gen_tmpl[i];
        if (c == fwm_pkg::QueryChar) begin
          name_buf.push_back(pick_char());
        end else if (c == fwm_pkg::StarChar) begin
          repeat ($urandom_range(0, 3)) name_buf.push_back(pick_char());
        end else if (gen_fold && c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) begin
          name_buf.push_back(c + fwm_pkg::CaseDelta);
        end else begin
          name_buf.push_back(c);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            if (name_buf.size() != 0) begin
              void'(name_buf.pop_back());
            end
          end
          1: begin
            if (name_buf.size() != 0) begin
              name_buf[$urandom_range(0, name_buf.size() - 1)] = pick_char();
            end
          end
          default: begin
            name_buf.push_back(pick_char());
          end
        endcase
      end
    end
  endtask

  // Main sequence: reset, directed table, then random phases.
  initial begin
    dir_row_t    row;
    int          tl;
    int unsigned phase_items;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct  = 13;
    sink_idle_pct = 60;
    for (int r = 0; r < DirRowCount; r++) begin
      row = dir_row(r);
      // The first row runs on the reset configuration.
      if (r != 0) begin
        tl = (row.tmpl_len > 12) ? 12 : row.tmpl_len;
        for (int i = 0; i < 12; i++) begin
          gen_tmpl[i] = (i < tl) ? text_byte(row.tmpl_text, tl, i) : 8'h00;
        end
        gen_len  = row.tmpl_len;
        gen_fold = row.fold;
        load_template();
      end
      name_buf.delete();
      for (int i = 0; i < row.name_len; i++) begin
        name_buf.push_back(text_byte({32'd0, row.name_text}, row.name_len, i));
      end
      send_name(row.kind);
      drain_verdicts();
    end

    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase < 8) begin
        src_idle_pct  = 13;
        sink_idle_pct = 60;
      end else if (phase < 16) begin
        src_idle_pct  = 60;
        sink_idle_pct = 13;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      new_template(phase);
      load_template();
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        build_name();
        send_name(VerdictPredicted);
        phase_items += name_buf.size() + 1;
        // Now and then the sender waits for every verdict to come back.
        if ($urandom_range(0, 39) == 0) begin
          drain_verdicts();
        end
      end
      drain_verdicts();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
